FILE: rtl/qfra_pkg.sv
package qfra_pkg;

  localparam int CONTRACT_SLOTS_DEF = 1024;
  localparam int CONTRACT_IDX_BITS  = 10;
  localparam int HOST_ID_BITS       = 8;
  localparam int VALUE_BITS         = 48;
  localparam int CFG_DATA_BITS      = 32;
  localparam int CFG_IDX_BITS       = 4;

  localparam logic [CFG_DATA_BITS-1:0] UPDATE_SLACK_RST = CFG_DATA_BITS'(15000);
  localparam logic [CFG_DATA_BITS-1:0] RACE_TIMEOUT_RST = CFG_DATA_BITS'(60 * 1000);

  localparam logic [CFG_IDX_BITS-1:0] CFG_UPDATE_SLACK = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_RACE_TIMEOUT = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    VERDICT_DROP     = 2'd0,
    VERDICT_LATEST   = 2'd1,
    VERDICT_OBSOLETE = 2'd2
  } verdict_t;

  typedef struct packed {
    logic                          platform_present;
    logic                          symbol_present;
    logic [CONTRACT_IDX_BITS-1:0]  contract_index;
    logic [HOST_ID_BITS-1:0]       source_host;
    logic signed [VALUE_BITS-1:0]  volume;
    logic signed [VALUE_BITS-1:0]  turnover;
    logic signed [VALUE_BITS-1:0]  last_qty;
    logic [VALUE_BITS-1:0]         update_ts_ms;
    logic [VALUE_BITS-1:0]         race_ts_ms;
  } in_item_t;

  typedef struct packed {
    verdict_t                      verdict;
    logic signed [VALUE_BITS-1:0]  last_qty_out;
    logic                          price_valid;
  } out_item_t;

  typedef struct packed {
    logic                    valid;
    logic [HOST_ID_BITS-1:0] host;
    logic [VALUE_BITS-1:0]   volume;
    logic [VALUE_BITS-1:0]   update_ts;
    logic [VALUE_BITS-1:0]   race_ts;
    logic [VALUE_BITS-1:0]   last_qty;
  } entry_t;

  typedef struct packed {
    logic                  lead;
    logic [VALUE_BITS-1:0] diff;
  } cmp_res_t;

endpackage

FILE: rtl/quote_feed_race_arbiter.sv
// Quote feed race arbiter. After reset the block sweeps the contract table
// once, clearing every slot with busy high; configuration writes are taken
// during the sweep and at any time (cfg_ready is always high). A quote is
// taken on start while busy is low. A dropped quote gives its result beat
// on the next cycle and busy stays low. The first quote of a contract has
// a table read, then a write; for a known contract, after the table read,
// one shared subtract/compare unit checks volume, update time and race
// time in turn. Results come out on out_strobe for a single cycle and
// cannot be stalled, so the receiver must take every beat as it appears.
module quote_feed_race_arbiter import qfra_pkg::*; #(
  parameter int CONTRACT_SLOTS = CONTRACT_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  in_item_t                 in_item,
  output logic                     out_strobe,
  output out_item_t                out_item,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int SLOT_W = (CONTRACT_SLOTS > 1) ? $clog2(CONTRACT_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(CONTRACT_SLOTS - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_VOL   = 6'b001000,
    S_UTS   = 6'b010000,
    S_RTS   = 6'b100000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [SLOT_W-1:0]        clr_r, clr_nxt;
  logic                     out_strobe_r, out_strobe_nxt;
  out_item_t                out_item_r, out_item_nxt;
  logic [CFG_DATA_BITS-1:0] slack_r, timeout_r;

  in_item_t                 item_r;
  logic [SLOT_W-1:0]        slot_r;
  logic                     vol_gt_r;
  logic [VALUE_BITS-1:0]    diff_r;
  logic                     lead_u_r;

  logic [31:0]              fold_v;
  logic [SLOT_W-1:0]        slot_fold;
  logic                     drop;
  logic                     accept;

  logic                     mem_we;
  logic [SLOT_W-1:0]        mem_waddr;
  entry_t                   mem_wdata;
  entry_t                   rd_ent;

  logic [VALUE_BITS-1:0]    cmp_a, cmp_b;
  logic [CFG_DATA_BITS-1:0] cmp_lim;
  cmp_res_t                 cmp_res;

  logic [VALUE_BITS-1:0]    q1, q2, adj_qty;
  logic                     latest;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // contract index folded into the table by compare/subtract of shifted depths
  always_comb begin
    fold_v = 32'(in_item.contract_index);
    for (int k = CONTRACT_IDX_BITS - 1; k >= 0; k--) begin
      if (fold_v >= (32'(CONTRACT_SLOTS) << k)) begin
        fold_v = fold_v - (32'(CONTRACT_SLOTS) << k);
      end
    end
  end
  assign slot_fold = fold_v[SLOT_W-1:0];

  assign drop = !in_item.platform_present || !in_item.symbol_present ||
                in_item.volume[VALUE_BITS-1] || in_item.turnover[VALUE_BITS-1];

  qfra_entry_ram #(
    .DEPTH  (CONTRACT_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (state_r == S_READ),
    .rd_addr (slot_r),
    .rd_data (rd_ent)
  );

  always_comb begin
    unique case (state_r)
      S_VOL: begin
        cmp_a   = item_r.volume;
        cmp_b   = rd_ent.volume;
        cmp_lim = '0;
      end
      S_UTS: begin
        cmp_a   = item_r.update_ts_ms;
        cmp_b   = rd_ent.update_ts;
        cmp_lim = slack_r;
      end
      default: begin
        cmp_a   = item_r.race_ts_ms;
        cmp_b   = rd_ent.race_ts;
        cmp_lim = timeout_r;
      end
    endcase
  end

  qfra_cmp_unit u_cmp (
    .op_a  (cmp_a),
    .op_b  (cmp_b),
    .limit (cmp_lim),
    .res   (cmp_res)
  );

  // last quantity fill-in: volume delta, then stored value
  always_comb begin
    q1 = (item_r.last_qty[VALUE_BITS-1] || item_r.last_qty == '0) ?
         diff_r : item_r.last_qty;
    q2 = (q1[VALUE_BITS-1] || q1 == '0) ? rd_ent.last_qty : q1;
    adj_qty = (item_r.volume != '0) ? q2 : item_r.last_qty;
  end

  assign latest = vol_gt_r || (rd_ent.host == item_r.source_host) ||
                  lead_u_r || cmp_res.lead;

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_waddr      = slot_r;
    mem_wdata.valid     = 1'b1;
    mem_wdata.host      = item_r.source_host;
    mem_wdata.volume    = item_r.volume;
    mem_wdata.update_ts = item_r.update_ts_ms;
    mem_wdata.race_ts   = item_r.race_ts_ms;
    mem_wdata.last_qty  = item_r.last_qty;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == SLOT_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (drop) begin
            out_strobe_nxt            = 1'b1;
            out_item_nxt.verdict      = VERDICT_DROP;
            out_item_nxt.last_qty_out = '0;
            out_item_nxt.price_valid  = 1'b0;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        state_nxt = S_VOL;
      end
      S_VOL: begin
        if (!rd_ent.valid) begin
          mem_we                    = 1'b1;
          out_strobe_nxt            = 1'b1;
          out_item_nxt.verdict      = VERDICT_LATEST;
          out_item_nxt.last_qty_out = item_r.last_qty;
          out_item_nxt.price_valid  = 1'b1;
          state_nxt                 = S_IDLE;
        end else begin
          state_nxt = S_UTS;
        end
      end
      S_UTS: begin
        state_nxt = S_RTS;
      end
      S_RTS: begin
        mem_we                    = latest;
        mem_wdata.last_qty        = adj_qty;
        out_strobe_nxt            = 1'b1;
        out_item_nxt.verdict      = latest ? VERDICT_LATEST : VERDICT_OBSOLETE;
        out_item_nxt.last_qty_out = adj_qty;
        out_item_nxt.price_valid  = (item_r.volume != '0);
        state_nxt                 = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      out_strobe_r <= 1'b0;
      slack_r      <= UPDATE_SLACK_RST;
      timeout_r    <= RACE_TIMEOUT_RST;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_UPDATE_SLACK: slack_r   <= cfg_data;
          CFG_RACE_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (accept) begin
      item_r <= in_item;
      slot_r <= slot_fold;
    end
    if (state_r == S_VOL) begin
      vol_gt_r <= cmp_res.lead;
      diff_r   <= cmp_res.diff;
    end
    if (state_r == S_UTS) begin
      lead_u_r <= cmp_res.lead;
    end
  end

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_RTS || state_r == S_VOL ||
                           (state_r == S_IDLE && start)))
    else $error("result beat without a finishing step");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_CLEAR || state_r == S_VOL || state_r == S_RTS))
    else $error("table write outside clear or commit");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_strobe_r))
    else $error("accepted beat neither worked on nor answered");

  a_drop_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_item_r.verdict == VERDICT_DROP) |->
      (out_item_r.last_qty_out == '0 && !out_item_r.price_valid))
    else $error("dropped quote with nonzero payload");

endmodule

FILE: rtl/qfra_cmp_unit.sv
module qfra_cmp_unit import qfra_pkg::*; (
  input  logic [VALUE_BITS-1:0]    op_a,
  input  logic [VALUE_BITS-1:0]    op_b,
  input  logic [CFG_DATA_BITS-1:0] limit,
  output cmp_res_t                 res
);

  logic [VALUE_BITS:0] sub_w;

  // lead: op_a > op_b and (op_a - op_b) > limit, unsigned, no wrap
  assign sub_w    = {1'b0, op_a} - {1'b0, op_b};
  assign res.diff = sub_w[VALUE_BITS-1:0];
  assign res.lead = !sub_w[VALUE_BITS] && (sub_w[VALUE_BITS-1:0] > VALUE_BITS'(limit));

endmodule

FILE: rtl/qfra_entry_ram.sv
module qfra_entry_ram import qfra_pkg::*; #(
  parameter int DEPTH  = CONTRACT_SLOTS_DEF,
  parameter int ADDR_W = $clog2(CONTRACT_SLOTS_DEF)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: dv/testbench.sv
module testbench;
  import qfra_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam longint MAX_TS = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint MAX_VOL = 64'h0000_7FFF_FFFF_FFFF;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_UPDATE_SLACK;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  quote_feed_race_arbiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // contract book as the block should hold it
  bit book_live [CONTRACT_SLOTS_DEF];
  longint book_volume [CONTRACT_SLOTS_DEF];
  longint book_update_ts [CONTRACT_SLOTS_DEF];
  longint book_race_ts [CONTRACT_SLOTS_DEF];
  logic [HOST_ID_BITS-1:0] book_host [CONTRACT_SLOTS_DEF];
  longint book_last_qty [CONTRACT_SLOTS_DEF];
  logic [CFG_DATA_BITS-1:0] slack_ms = UPDATE_SLACK_RST;
  logic [CFG_DATA_BITS-1:0] timeout_ms = RACE_TIMEOUT_RST;

  out_item_t expected_verdicts [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic bit leads_by(longint now_ms, longint old_ms, logic [31:0] lim);
    return now_ms > old_ms && (now_ms - old_ms) > longint'({32'b0, lim});
  endfunction

  function automatic out_item_t arbitrate_quote(input in_item_t q);
    out_item_t r;
    longint vol;
    longint turn;
    longint qty;
    longint uts;
    longint rts;
    int unsigned slot;
    bit wins;
    r = '0;
    vol = {{16{q.volume[VALUE_BITS-1]}}, q.volume};
    turn = {{16{q.turnover[VALUE_BITS-1]}}, q.turnover};
    qty = {{16{q.last_qty[VALUE_BITS-1]}}, q.last_qty};
    uts = {16'b0, q.update_ts_ms};
    rts = {16'b0, q.race_ts_ms};
    slot = q.contract_index;
    if (!q.platform_present || !q.symbol_present || vol < 0 || turn < 0) begin
      r.verdict = VERDICT_DROP;
      return r;
    end
    if (!book_live[slot]) begin
      book_live[slot] = 1'b1;
      book_volume[slot] = vol;
      book_update_ts[slot] = uts;
      book_race_ts[slot] = rts;
      book_host[slot] = q.source_host;
      book_last_qty[slot] = qty;
      r.verdict = VERDICT_LATEST;
      r.last_qty_out = q.last_qty;
      r.price_valid = 1'b1;
      return r;
    end
    r.price_valid = 1'b1;
    if (vol > 0) begin
      if (qty <= 0) qty = vol - book_volume[slot];
      if (qty <= 0) qty = book_last_qty[slot];
    end else begin
      r.price_valid = 1'b0;
    end
    wins = book_volume[slot] < vol || book_host[slot] == q.source_host
        || leads_by(uts, book_update_ts[slot], slack_ms)
        || leads_by(rts, book_race_ts[slot], timeout_ms);
    if (wins) begin
      book_volume[slot] = vol;
      book_update_ts[slot] = uts;
      book_race_ts[slot] = rts;
      book_host[slot] = q.source_host;
      book_last_qty[slot] = qty;
    end
    r.verdict = wins ? VERDICT_LATEST : VERDICT_OBSOLETE;
    r.last_qty_out = qty[VALUE_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst_n && out_strobe) begin
      if (expected_verdicts.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result beat: verdict %0d last_qty %0d price_valid %0b",
                   out_item.verdict, $signed(out_item.last_qty_out), out_item.price_valid);
        mismatch_count++;
      end else begin
        exp_item = expected_verdicts.pop_front();
        if (out_item.verdict !== exp_item.verdict
            || out_item.last_qty_out !== exp_item.last_qty_out
            || out_item.price_valid !== exp_item.price_valid) begin
          if (mismatch_count < 10)
            $display("mismatch: verdict exp %0d got %0d, last_qty exp %0d got %0d, %s %0b got %0b",
                     exp_item.verdict, out_item.verdict,
                     $signed(exp_item.last_qty_out), $signed(out_item.last_qty_out),
                     "price_valid exp", exp_item.price_valid, out_item.price_valid);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[47:0];
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t quote_of(logic [9:0] slot, logic [7:0] host,
                                        logic [47:0] vol, logic [47:0] turn,
                                        logic [47:0] qty, logic [47:0] uts,
                                        logic [47:0] rts);
    in_item_t q;
    q.platform_present = 1'b1;
    q.symbol_present = 1'b1;
    q.contract_index = slot;
    q.source_host = host;
    q.volume = vol;
    q.turnover = turn;
    q.last_qty = qty;
    q.update_ts_ms = uts;
    q.race_ts_ms = rts;
    return q;
  endfunction

  // timestamps often land near the current lead limit, else around the base or at random
  function automatic logic [47:0] step_ts(longint base, logic [31:0] lim);
    longint v;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) v = base - longint'($urandom_range(0, 2000));
    else if (r < 45) v = base + longint'($urandom_range(0, 2000));
    else if (r < 80) v = base + longint'({32'b0, lim}) + longint'($urandom_range(0, 2)) - 1;
    else if (r < 95) v = base + longint'($urandom_range(0, 200000));
    else return rand48();
    if (v < 0) v = 0;
    if (v > MAX_TS) v = MAX_TS;
    return v[47:0];
  endfunction

  function automatic in_item_t random_quote();
    in_item_t q;
    int unsigned r;
    int unsigned slot;
    longint vol;
    longint qty;
    longint base_uts;
    longint base_rts;
    q.platform_present = 1'b1;
    q.symbol_present = 1'b1;
    if ($urandom_range(99) < 5) begin
      q.platform_present = $urandom_range(1);
      q.symbol_present = $urandom_range(1);
    end
    r = $urandom_range(99);
    if (r < 70) slot = $urandom_range(15);
    else if (r < 80) slot = r[0] ? 1023 : 0;
    else slot = $urandom_range(1023);
    q.contract_index = slot[9:0];
    if ($urandom_range(3) != 0) q.source_host = 8'($urandom_range(3));
    else q.source_host = 8'($urandom_range(255));
    if (book_live[slot]) begin
      vol = book_volume[slot];
      base_uts = book_update_ts[slot];
      base_rts = book_race_ts[slot];
    end else begin
      vol = $urandom_range(1000);
      base_uts = $urandom();
      base_rts = $urandom();
    end
    r = $urandom_range(99);
    if (r < 30) vol = vol;
    else if (r < 60) vol = vol + longint'($urandom_range(1, 100));
    else if (r < 75) vol = vol - longint'($urandom_range(1, 100));
    else if (r < 85) vol = 0;
    else vol = longint'(rand48() >> 1);
    if (vol < 0) vol = 0;
    if (vol > MAX_VOL) vol = MAX_VOL;
    q.volume = vol[47:0];
    if (r >= 97) begin
      q.volume = rand48();
      q.volume[47] = 1'b1;
    end
    q.turnover = rand48();
    q.turnover[47] = ($urandom_range(99) < 3);
    r = $urandom_range(99);
    if (r < 40) qty = 0;
    else if (r < 60) qty = -longint'($urandom_range(1, 500));
    else if (r < 90) qty = $urandom_range(1, 500);
    else qty = {{16{1'b0}}, rand48()};
    q.last_qty = qty[47:0];
    q.update_ts_ms = step_ts(base_uts, slack_ms);
    q.race_ts_ms = step_ts(base_rts, timeout_ms);
    return q;
  endfunction

  task automatic send_quote(input in_item_t q, input int unsigned gap);
    start <= 1'b1;
    in_item <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_verdicts.push_back(arbitrate_quote(q));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    if (start) start <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_timing(input logic [31:0] slack, input logic [31:0] timeout);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_UPDATE_SLACK;
    cfg_data <= slack;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    slack_ms = slack;
    cfg_index <= CFG_RACE_TIMEOUT;
    cfg_data <= timeout;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    timeout_ms = timeout;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_dropped_quotes();
    in_item_t q;
    q = quote_of(10'd3, 8'd1, 48'd10, 48'd10, 48'd1, 48'd100, 48'd100);
    q.platform_present = 1'b0;
    send_quote(q, pick_gap());
    q.platform_present = 1'b1;
    q.symbol_present = 1'b0;
    send_quote(q, 0);
    send_quote(quote_of(10'd3, 8'd1, 48'h8000_0000_0000, 48'd10, 48'd1, 48'd100, 48'd100),
               pick_gap());
    send_quote(quote_of(10'd3, 8'd1, 48'd10, 48'hFFFF_FFFF_FFFF, 48'd1, 48'd100, 48'd100), 0);
    // slot must still be fresh; zero volume first quote keeps price valid
    send_quote(quote_of(10'd3, 8'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0), pick_gap());
  endtask

  task automatic test_first_quote_and_fill_in();
    send_quote(quote_of(10'd1023, 8'd255, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                        48'h7FFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF), 0);
    send_quote(quote_of(10'd1023, 8'd254, 48'h7FFF_FFFF_FFFF, 48'd5,
                        48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF),
               pick_gap());
    send_quote(quote_of(10'd1023, 8'd255, 48'd0, 48'd5,
                        48'h8000_0000_0000, 48'd0, 48'd0), pick_gap());
  endtask

  task automatic test_lead_boundaries();
    send_quote(quote_of(10'd0, 8'd0, 48'd100, 48'd1, 48'd0, 48'd1000, 48'd5000), 0);
    send_quote(quote_of(10'd0, 8'd1, 48'd150, 48'd1, 48'd0, 48'd1000, 48'd5000), pick_gap());
    // leads exactly at the limits do not win; leads one past them do
    send_quote(quote_of(10'd0, 8'd2, 48'd150, 48'd1, -48'sd5, 48'd16000, 48'd65000), 0);
    send_quote(quote_of(10'd0, 8'd2, 48'd150, 48'd1, 48'd7, 48'd16001, 48'd5000), pick_gap());
    send_quote(quote_of(10'd0, 8'd3, 48'd150, 48'd1, 48'd0, 48'd900, 48'd65001), 0);
    send_quote(quote_of(10'd0, 8'd4, 48'd140, 48'd1, 48'd3, 48'd899, 48'd65000), pick_gap());
    send_quote(quote_of(10'd0, 8'd3, 48'd140, 48'd1, 48'd3, 48'd0, 48'd0), 0);
  endtask

  task automatic test_random_feeds();
    logic [31:0] slack_set [6];
    logic [31:0] timeout_set [6];
    bit calm;
    slack_set = '{UPDATE_SLACK_RST, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd0};
    timeout_set = '{RACE_TIMEOUT_RST, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0};
    calm = 1'b0;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      if (p == 5) begin
        program_timing($urandom_range(1, 100000), $urandom_range(1, 300000));
      end else begin
        program_timing(slack_set[p], timeout_set[p]);
      end
      for (int i = 0; i < 267; i++) begin
        if (i % 64 == 0) calm = ($urandom_range(3) == 0);
        send_quote(random_quote(), calm ? 0 : pick_gap());
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_dropped_quotes();
    test_first_quote_and_fill_in();
    test_lead_boundaries();
    test_random_feeds();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
